@@ rtl/heightmap_bilinear_sampler_unit_macros.svh @@
// Assertion macros for the height map sampler.
// Expects aclk and aresetn in the including scope.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define HBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/hbs_pkg.sv @@
// Shared constants and types for the height map sampler.
// No dependencies.
package hbs_pkg;

    localparam int STORE_DEPTH    = 65536;
    localparam int STORE_AW       = 16;
    localparam int CELL_W         = 16;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // normalization divider sizing
    localparam int DIV_NW = 47;
    localparam int DIV_DW = 32;
    localparam int DIV_QW = 15;

    typedef enum logic [1:0] {
        CFG_INV_WORLD_SCALE,
        CFG_HEIGHT_SCALE,
        CFG_MAP_WIDTH,
        CFG_MAP_HEIGHT
    } cfg_idx_t;

endpackage

@@ rtl/hbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/hbs_sqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
// No dependencies.
module hbs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output logic        done
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                v_reg    <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'd1 << 62;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (v_reg >= trial) begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = res_reg[31:0];
    assign done = done_reg;

endmodule

@@ rtl/hbs_div.sv @@
// Restoring divider, one quotient bit per cycle; quotient must fit QW bits.
// No dependencies.
module hbs_div #(
    parameter int NW = 47,
    parameter int DW = 32,
    parameter int QW = 15
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic          done
);

    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= num;
                dsh_reg  <= {{(NW-DW){1'b0}}, den} << (QW - 1);
                quo_reg  <= '0;
                cnt_reg  <= CW'(QW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[QW-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

@@ rtl/heightmap_bilinear_sampler_unit.sv @@
// Height map sampler: bilinear height plus central-difference unit normal.
// Flow: an accepted query beat scales x and z, then takes 5 samples (4 store reads, then mix,
// multiply, divide by 65535, saturate), then slopes, a root, a normalize and the output register.
// A new query is taken only when idle, once the previous result is in the output register;
// a write beat is taken when idle and gives no result.
// Reset (aresetn low, synchronous) loads register defaults; map store is not cleared.
// Depends on hbs_pkg, hbs_ram, hbs_sqrt, hbs_div and the assertion macro header.
`include "heightmap_bilinear_sampler_unit_macros.svh"

module heightmap_bilinear_sampler_unit #(
    parameter int MAX_MAP_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_MAP_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [15:0]        s_cell_index,
    input  logic [15:0]        s_cell_height,
    input  logic signed [23:0] s_world_x,
    input  logic signed [23:0] s_world_z,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_height,
    output logic signed [15:0] m_normal_x,
    output logic [14:0]        m_normal_y,
    output logic signed [15:0] m_normal_z
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCX, ST_SCZ, ST_READ, ST_MIX0, ST_MIX1, ST_MIX2,
        ST_HMUL, ST_HDIV, ST_HFIX, ST_DIFF, ST_MAG, ST_SQX, ST_SQZ,
        ST_SUM, ST_SQRT, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [23:0] inv_scale_reg;
    logic [31:0] hscale_reg;
    logic [8:0]  map_w_reg;
    logic [8:0]  map_h_reg;
    logic [8:0]  w_eff, h_eff;

    // query registers
    logic signed [23:0] wx_reg, wz_reg;
    logic signed [23:0] x0_reg, z0_reg;
    logic [15:0]        fx_reg, fz_reg;
    logic [2:0]         samp_idx_reg;
    logic [2:0]         rd_cnt_reg;
    logic [15:0]        cell_reg [4];
    logic [31:0]        r0_reg, r1_reg, b_reg;
    logic [63:0]        p_reg;
    logic [33:0]        q1_reg;
    logic [31:0]        samp_reg [5];
    logic signed [32:0] dx_reg, dz_reg;
    logic [30:0]        ax_reg, az_reg;
    logic               shift_reg;
    logic [61:0]        sqx_reg, sqz_reg;
    logic [31:0]        root_reg;
    // normal held until the output register is free
    logic signed [15:0] nx_reg, nz_reg;
    logic [14:0]        ny_reg;

    // output register
    logic               m_valid_reg;
    logic [31:0]        m_height_reg;
    logic signed [15:0] m_nx_reg, m_nz_reg;
    logic [14:0]        m_ny_reg;

    // effective map size, clamped to [1, MAX]
    always_comb begin
        if (map_w_reg == 9'd0) begin
            w_eff = 9'd1;
        end else if (32'(map_w_reg) > MAX_MAP_WIDTH) begin
            w_eff = 9'(MAX_MAP_WIDTH);
        end else begin
            w_eff = map_w_reg;
        end
        if (map_h_reg == 9'd0) begin
            h_eff = 9'd1;
        end else if (32'(map_h_reg) > MAX_MAP_HEIGHT) begin
            h_eff = 9'(MAX_MAP_HEIGHT);
        end else begin
            h_eff = map_h_reg;
        end
    end

    // read address: sample offset plus corner, clamped to the map edge
    logic signed [24:0] ox, oz, cx, cz;
    logic [8:0]         tx, tz;
    logic [17:0]        lin_addr;

    always_comb begin
        ox = '0;
        oz = '0;
        case (samp_idx_reg)
            3'd1: ox = -25'sd1;
            3'd2: ox = 25'sd1;
            3'd3: oz = -25'sd1;
            3'd4: oz = 25'sd1;
            default: begin
                ox = '0;
                oz = '0;
            end
        endcase
        cx = {x0_reg[23], x0_reg} + ox + $signed({24'b0, rd_cnt_reg[0]});
        cz = {z0_reg[23], z0_reg} + oz + $signed({24'b0, rd_cnt_reg[1]});
        if (cx[24]) begin
            tx = '0;
        end else if (cx > $signed({16'b0, w_eff - 9'd1})) begin
            tx = w_eff - 9'd1;
        end else begin
            tx = cx[8:0];
        end
        if (cz[24]) begin
            tz = '0;
        end else if (cz > $signed({16'b0, h_eff - 9'd1})) begin
            tz = h_eff - 9'd1;
        end else begin
            tz = cz[8:0];
        end
        lin_addr = {9'b0, tz} * {9'b0, w_eff} + {9'b0, tx};
    end

    // map store
    logic        ram_we, ram_re;
    logic [15:0] ram_rdata;

    assign s_ready = (state_reg == ST_IDLE);
    assign ram_we  = s_valid && s_ready && !s_op;
    assign ram_re  = (state_reg == ST_READ) && (rd_cnt_reg < 3'd4);

    hbs_ram #(
        .DATA_W (hbs_pkg::CELL_W),
        .DEPTH  (hbs_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_cell_index),
        .wdata (s_cell_height),
        .re    (ram_re),
        .raddr (lin_addr[15:0]),
        .rdata (ram_rdata)
    );

    // datapath arithmetic for the current state
    logic signed [48:0] scale_prod;
    logic signed [16:0] row_diff;
    logic signed [33:0] row_mix;
    logic signed [32:0] col_diff;
    logic signed [49:0] col_mix;
    logic [47:0]        hn;
    logic [49:0]        q1_sum;
    logic [50:0]        hrem;
    logic [34:0]        hq;
    logic [15:0]        cell_a, cell_b;
    logic [15:0]        frac;
    logic [32:0]        adx, adz;

    always_comb begin
        scale_prod = ((state_reg == ST_SCX) ? wx_reg : wz_reg)
                     * $signed({1'b0, inv_scale_reg});
        cell_a   = (state_reg == ST_MIX0) ? cell_reg[0] : cell_reg[2];
        cell_b   = (state_reg == ST_MIX0) ? cell_reg[1] : cell_reg[3];
        frac     = fx_reg;
        row_diff = $signed({1'b0, cell_b}) - $signed({1'b0, cell_a});
        row_mix  = $signed({2'b0, cell_a, 16'b0}) + row_diff * $signed({1'b0, frac});
        col_diff = $signed({1'b0, r1_reg}) - $signed({1'b0, r0_reg});
        col_mix  = $signed({2'b0, r0_reg, 16'b0}) + col_diff * $signed({1'b0, fz_reg})
                   + 50'sd32768;
        // divide by 65535: n/2^16 * (1 + 2^-16 + 2^-32), then one correction
        hn     = p_reg[63:16];
        q1_sum = 50'(hn) + 50'(hn >> 16) + 50'(hn >> 32);
        hrem   = 51'(hn) + 51'(q1_reg) - {1'b0, q1_reg, 16'b0};
        hq     = 35'(q1_reg) + ((hrem >= 51'd65535) ? 35'd1 : 35'd0);
        adx    = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        adz    = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);
    end

    // root and normalization units
    logic        sqrt_start, sqrt_done;
    logic [31:0] sqrt_root;
    logic [63:0] radicand;
    logic        div_start;
    logic        dvx_done, dvy_done, dvz_done;
    logic [14:0] qx, qy, qz;
    logic [14:0] qx_c, qy_c, qz_c;
    logic [17:0] ay_mag;

    assign ay_mag     = shift_reg ? 18'd65536 : 18'd131072;
    assign radicand   = 64'(sqx_reg) + 64'(sqz_reg)
                        + (shift_reg ? (64'd1 << 32) : (64'd1 << 34));
    assign sqrt_start = (state_reg == ST_SUM);
    assign div_start  = (state_reg == ST_SQRT) && sqrt_done;

    hbs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    hbs_div #(.NW(hbs_pkg::DIV_NW), .DW(hbs_pkg::DIV_DW), .QW(hbs_pkg::DIV_QW)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({2'b0, ax_reg, 14'b0} + 47'(sqrt_root >> 1)),
        .den     (sqrt_root),
        .quo     (qx),
        .done    (dvx_done)
    );

    hbs_div #(.NW(hbs_pkg::DIV_NW), .DW(hbs_pkg::DIV_DW), .QW(hbs_pkg::DIV_QW)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({15'b0, ay_mag, 14'b0} + 47'(sqrt_root >> 1)),
        .den     (sqrt_root),
        .quo     (qy),
        .done    (dvy_done)
    );

    hbs_div #(.NW(hbs_pkg::DIV_NW), .DW(hbs_pkg::DIV_DW), .QW(hbs_pkg::DIV_QW)) u_div_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     ({2'b0, az_reg, 14'b0} + 47'(sqrt_root >> 1)),
        .den     (sqrt_root),
        .quo     (qz),
        .done    (dvz_done)
    );

    // cap at 1.0 in Q1.14
    assign qx_c = (qx > 15'd16384) ? 15'd16384 : qx;
    assign qy_c = (qy > 15'd16384) ? 15'd16384 : qy;
    assign qz_c = (qz > 15'd16384) ? 15'd16384 : qz;

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            inv_scale_reg <= 24'd65536;
            hscale_reg    <= 32'd65536;
            map_w_reg     <= 9'd256;
            map_h_reg     <= 9'd256;
            samp_idx_reg  <= '0;
            rd_cnt_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (hbs_pkg::cfg_idx_t'(cfg_index))
                    hbs_pkg::CFG_INV_WORLD_SCALE: inv_scale_reg <= cfg_wdata[23:0];
                    hbs_pkg::CFG_HEIGHT_SCALE:    hscale_reg    <= cfg_wdata;
                    hbs_pkg::CFG_MAP_WIDTH:       map_w_reg     <= cfg_wdata[8:0];
                    hbs_pkg::CFG_MAP_HEIGHT:      map_h_reg     <= cfg_wdata[8:0];
                    default: ;
                endcase
            end

            // ST_OUT reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_op) begin
                        wx_reg    <= s_world_x;
                        wz_reg    <= s_world_z;
                        state_reg <= ST_SCX;
                    end
                end
                ST_SCX: begin
                    x0_reg    <= scale_prod[47:24];
                    fx_reg    <= scale_prod[23:8];
                    state_reg <= ST_SCZ;
                end
                ST_SCZ: begin
                    z0_reg       <= scale_prod[47:24];
                    fz_reg       <= scale_prod[23:8];
                    samp_idx_reg <= '0;
                    rd_cnt_reg   <= '0;
                    state_reg    <= ST_READ;
                end
                ST_READ: begin
                    // address goes out on counts 0..3, data lands on counts 1..4
                    if (rd_cnt_reg != 3'd0) begin
                        cell_reg[2'(rd_cnt_reg - 3'd1)] <= ram_rdata;
                    end
                    if (rd_cnt_reg == 3'd4) begin
                        state_reg <= ST_MIX0;
                    end
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                end
                ST_MIX0: begin
                    r0_reg    <= row_mix[31:0];
                    state_reg <= ST_MIX1;
                end
                ST_MIX1: begin
                    r1_reg    <= row_mix[31:0];
                    state_reg <= ST_MIX2;
                end
                ST_MIX2: begin
                    b_reg     <= col_mix[47:16];
                    state_reg <= ST_HMUL;
                end
                ST_HMUL: begin
                    p_reg     <= 64'(b_reg) * 64'(hscale_reg);
                    state_reg <= ST_HDIV;
                end
                ST_HDIV: begin
                    q1_reg    <= q1_sum[49:16];
                    state_reg <= ST_HFIX;
                end
                ST_HFIX: begin
                    samp_reg[samp_idx_reg] <= (hq > 35'hFFFF_FFFF) ? 32'hFFFF_FFFF : hq[31:0];
                    rd_cnt_reg <= '0;
                    if (samp_idx_reg == 3'd4) begin
                        state_reg <= ST_DIFF;
                    end else begin
                        samp_idx_reg <= samp_idx_reg + 3'd1;
                        state_reg    <= ST_READ;
                    end
                end
                ST_DIFF: begin
                    dx_reg    <= $signed({1'b0, samp_reg[1]}) - $signed({1'b0, samp_reg[2]});
                    dz_reg    <= $signed({1'b0, samp_reg[3]}) - $signed({1'b0, samp_reg[4]});
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    // halve all three when a slope reaches 2^31
                    if (adx[32:31] != 2'b00 || adz[32:31] != 2'b00) begin
                        shift_reg <= 1'b1;
                        ax_reg    <= adx[31:1];
                        az_reg    <= adz[31:1];
                    end else begin
                        shift_reg <= 1'b0;
                        ax_reg    <= adx[30:0];
                        az_reg    <= adz[30:0];
                    end
                    state_reg <= ST_SQX;
                end
                ST_SQX: begin
                    sqx_reg   <= 62'(ax_reg) * 62'(ax_reg);
                    state_reg <= ST_SQZ;
                end
                ST_SQZ: begin
                    sqz_reg   <= 62'(az_reg) * 62'(az_reg);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        root_reg  <= sqrt_root;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (dvx_done) begin
                        nx_reg    <= dx_reg[32] ? -$signed({1'b0, qx_c}) : $signed({1'b0, qx_c});
                        ny_reg    <= qy_c;
                        nz_reg    <= dz_reg[32] ? -$signed({1'b0, qz_c}) : $signed({1'b0, qz_c});
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_height_reg <= samp_reg[0];
                        m_nx_reg     <= nx_reg;
                        m_ny_reg     <= ny_reg;
                        m_nz_reg     <= nz_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_height   = m_height_reg;
    assign m_normal_x = m_nx_reg;
    assign m_normal_y = m_ny_reg;
    assign m_normal_z = m_nz_reg;

    // checks
    `HBS_ASSERT_NEXT(a_query_blocks, s_valid && s_ready && s_op, !s_ready, "query did not block input")
    `HBS_ASSERT_NOW(a_div_lockstep, dvx_done, dvy_done && dvz_done, "divider lanes out of step")
    `HBS_ASSERT_NOW(a_ny_range, m_valid, m_normal_y <= 15'd16384, "normal y above one")
    `HBS_ASSERT_NOW(a_root_nonzero, state_reg == ST_DIV, root_reg != 32'd0, "zero root in normalize")

endmodule
